>>> hdl/xor_checked_frame_parser_macros.svh
// Assertion macros shared by the frame parser modules.
// Included by every file that carries concurrent assertions; no other dependencies.
`ifndef XOR_CHECKED_FRAME_PARSER_MACROS_SVH
`define XOR_CHECKED_FRAME_PARSER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define XCFP_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("xcfp assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define XCFP_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("xcfp assertion failed");

`endif

>>> hdl/xcfp_pkg.sv
// Package of the XOR checked frame parser: frame constants, status codes and word types.
// Used by every module of the parser; depends on nothing.
`default_nettype none

package xcfp_pkg;

    localparam logic [7:0] HEAD_A        = 8'hEE;
    localparam logic [7:0] HEAD_B        = 8'h66;
    localparam logic [7:0] LEN_BIAS      = 8'd8;
    localparam logic [7:0] PAYLOAD_START = 8'd9;
    localparam logic [7:0] MIN_LAST_POS  = 8'd10;
    localparam logic [7:0] SESSION_START = 8'd3;
    localparam int         SESSION_BYTES = 6;

    typedef enum logic [2:0] {
        ST_OK           = 3'd0,
        ST_TOO_SHORT    = 3'd1,
        ST_BAD_HEAD     = 3'd2,
        ST_BAD_LENGTH   = 3'd3,
        ST_BAD_CHECKSUM = 3'd4,
        ST_OVERRUN      = 3'd5
    } t_status;

    typedef enum logic {
        KIND_PAYLOAD   = 1'b0,
        KIND_FRAME_END = 1'b1
    } t_kind;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_in_word;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  payload_byte;
        logic [7:0]  payload_index;
        logic [7:0]  command;
        logic [47:0] session_id;
        logic [7:0]  payload_length;
        t_status     frame_status;
    } t_result;

    typedef struct packed {
        logic item_valid;
        logic advance;
    } t_pipe_ctrl;

endpackage

`default_nettype wire

>>> hdl/xcfp_in_stage.sv
// Input register of the frame parser: captures one received word per accepted handshake.
// Depends on xcfp_pkg.
`default_nettype none

module xcfp_in_stage
    import xcfp_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_valid,
    output logic          o_ready,
    input  wire t_in_word i_word,
    input  wire logic     i_advance,
    output logic          o_valid,
    output t_in_word      o_word
);

    logic     r_valid;
    t_in_word r_word;

    assign o_ready = i_advance || !r_valid;
    assign o_valid = r_valid;
    assign o_word  = r_word;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready) begin
            r_word <= i_word;
        end
    end

endmodule

`default_nettype wire

>>> hdl/xcfp_parse.sv
// Frame state and per-word decode: header capture, running XOR, payload and status logic.
// Depends on xcfp_pkg and the assertion macros header.
`default_nettype none
`include "xor_checked_frame_parser_macros.svh"

module xcfp_parse
    import xcfp_pkg::*;
#(
    parameter int MAX_POSITION = 511
)
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire t_pipe_ctrl i_ctrl,
    input  wire t_in_word   i_word,
    output logic            o_emit,
    output t_result         o_result
);

    localparam int POS_W = $clog2(MAX_POSITION + 1);

    logic [POS_W-1:0] r_pos, n_pos;
    logic [7:0]       r_head, n_head;
    logic [7:0]       r_len, n_len;
    logic [7:0]       r_cmd, n_cmd;
    logic [47:0]      r_session, n_session;
    logic [7:0]       r_xor, n_xor;

    logic [POS_W-1:0] len_ext;
    logic [POS_W-1:0] pay_offset;
    logic             len_ok;
    logic             in_payload;
    logic             take;
    t_status          status;

    assign len_ext    = POS_W'(r_len);
    assign pay_offset = r_pos - POS_W'(PAYLOAD_START);
    assign len_ok     = r_len > LEN_BIAS;
    assign in_payload = len_ok && (r_pos >= POS_W'(PAYLOAD_START)) && (r_pos <= len_ext);
    assign take       = i_ctrl.item_valid && i_ctrl.advance;

    always_comb begin
        if (r_pos < POS_W'(MIN_LAST_POS)) begin
            status = ST_TOO_SHORT;
        end else if (r_head != HEAD_A && r_head != HEAD_B) begin
            status = ST_BAD_HEAD;
        end else if (!len_ok) begin
            status = ST_BAD_LENGTH;
        end else if (r_pos <= len_ext) begin
            status = ST_OVERRUN;
        end else if (r_xor != i_word.data) begin
            status = ST_BAD_CHECKSUM;
        end else begin
            status = ST_OK;
        end
    end

    always_comb begin
        o_result = '0;
        o_emit   = 1'b0;
        if (i_ctrl.item_valid) begin
            if (i_word.last) begin
                o_emit                = 1'b1;
                o_result.kind         = KIND_FRAME_END;
                o_result.frame_status = status;
                if (status == ST_OK) begin
                    o_result.command        = r_cmd;
                    o_result.session_id     = r_session;
                    o_result.payload_length = r_len - LEN_BIAS;
                end
            end else if (in_payload) begin
                o_emit                 = 1'b1;
                o_result.kind          = KIND_PAYLOAD;
                o_result.payload_byte  = i_word.data;
                o_result.payload_index = pay_offset[7:0];
            end
        end
    end

    always_comb begin
        n_pos     = r_pos;
        n_head    = r_head;
        n_len     = r_len;
        n_cmd     = r_cmd;
        n_session = r_session;
        n_xor     = r_xor;
        if (take) begin
            if (i_word.last) begin
                n_pos     = '0;
                n_head    = '0;
                n_len     = '0;
                n_cmd     = '0;
                n_session = '0;
                n_xor     = '0;
            end else begin
                if (r_pos == '0) begin
                    n_head = i_word.data;
                end
                if (r_pos == POS_W'(1)) begin
                    n_len = i_word.data;
                end
                if (r_pos == POS_W'(2)) begin
                    n_cmd = i_word.data;
                end
                for (int k = 0; k < SESSION_BYTES; k++) begin
                    if (r_pos == POS_W'(int'(SESSION_START) + k)) begin
                        n_session[k*8 +: 8] = i_word.data;
                    end
                end
                if (r_pos != '0) begin
                    n_xor = r_xor ^ i_word.data;
                end
                if (r_pos < POS_W'(MAX_POSITION)) begin
                    n_pos = r_pos + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos     <= '0;
            r_head    <= '0;
            r_len     <= '0;
            r_cmd     <= '0;
            r_session <= '0;
            r_xor     <= '0;
        end else begin
            r_pos     <= n_pos;
            r_head    <= n_head;
            r_len     <= n_len;
            r_cmd     <= n_cmd;
            r_session <= n_session;
            r_xor     <= n_xor;
        end
    end

    `XCFP_ASSERT_NEXT(a_clear_after_last, i_clk, i_rst_n, take && i_word.last, r_pos == '0 && r_xor == '0 && r_len == '0)

endmodule

`default_nettype wire

>>> hdl/xcfp_out_stage.sv
// Result register of the frame parser: holds one result word until the sink takes it.
// Depends on xcfp_pkg.
`default_nettype none

module xcfp_out_stage
    import xcfp_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_emit,
    input  wire t_result i_result,
    input  wire logic    i_ready,
    output logic         o_advance,
    output logic         o_valid,
    output t_result      o_result
);

    logic    r_valid;
    t_result r_result;

    assign o_advance = !r_valid || i_ready;
    assign o_valid   = r_valid;
    assign o_result  = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_advance) begin
            r_valid <= i_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_advance) begin
            r_result <= i_result;
        end
    end

endmodule

`default_nettype wire

>>> hdl/xor_checked_frame_parser.sv
// An accepted input word is held in the input register; its result word is then held
// in the result register.
// Throughput: one word per cycle; the input stalls only while a result waits unread.
// Reset (synchronous, active low) empties both registers and clears all frame state.
// Top level of the XOR checked frame parser; depends on xcfp_pkg and the macros header.
`default_nettype none
`include "xor_checked_frame_parser_macros.svh"

module xor_checked_frame_parser
    import xcfp_pkg::*;
#(
    parameter int MAX_POSITION = 511
)
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [7:0]  i_s_axis_tdata,  // [7:0] data_byte
    input  wire logic        i_s_axis_tlast,  // end_of_buffer
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    // [7:0] payload_byte, [15:8] payload_index, [23:16] command,
    // [71:24] session_id, [79:72] payload_length, [82:80] frame_status
    output logic [87:0]      o_m_axis_tdata,
    output logic             o_m_axis_tuser   // kind
);

    t_in_word   in_word;
    t_in_word   stage_word;
    logic       stage_valid;
    logic       advance;
    t_pipe_ctrl ctrl;
    logic       emit;
    t_result    result;
    t_result    out_result;

    assign in_word.data = i_s_axis_tdata;
    assign in_word.last = i_s_axis_tlast;

    assign ctrl.item_valid = stage_valid;
    assign ctrl.advance    = advance;

    xcfp_in_stage u_in_stage (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_s_axis_tvalid),
        .o_ready   (o_s_axis_tready),
        .i_word    (in_word),
        .i_advance (advance),
        .o_valid   (stage_valid),
        .o_word    (stage_word)
    );

    xcfp_parse #(
        .MAX_POSITION (MAX_POSITION)
    ) u_parse (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctrl   (ctrl),
        .i_word   (stage_word),
        .o_emit   (emit),
        .o_result (result)
    );

    xcfp_out_stage u_out_stage (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_emit    (emit),
        .i_result  (result),
        .i_ready   (i_m_axis_tready),
        .o_advance (advance),
        .o_valid   (o_m_axis_tvalid),
        .o_result  (out_result)
    );

    assign o_m_axis_tuser = out_result.kind;
    assign o_m_axis_tdata = {5'b0, out_result.frame_status, out_result.payload_length,
                             out_result.session_id, out_result.command,
                             out_result.payload_index, out_result.payload_byte};

    `XCFP_ASSERT_SAME(a_stall_only_when_full, i_clk, i_rst_n, !o_s_axis_tready, o_m_axis_tvalid)
    `XCFP_ASSERT_SAME(a_payload_word_clean, i_clk, i_rst_n, o_m_axis_tvalid && out_result.kind == KIND_PAYLOAD, o_m_axis_tdata[87:16] == '0)
    `XCFP_ASSERT_SAME(a_failed_frame_clean, i_clk, i_rst_n, o_m_axis_tvalid && out_result.kind == KIND_FRAME_END && out_result.frame_status != ST_OK, o_m_axis_tdata[79:0] == '0)

endmodule

`default_nettype wire
